### design/tnlf_pkg.sv
// Package for the Telnet noise line framer.
// Holds the protocol byte codes, the decoder phase type and the result record type.
// Depends on nothing.
package tnlf_pkg;

	localparam logic [7:0] CODE_WILL = 8'd251;
	localparam logic [7:0] CODE_DO   = 8'd253;
	localparam logic [7:0] CODE_IAC  = 8'd255;
	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_LF   = 8'd10;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_IAC  = 2'd1,
		PH_OPT  = 2'd2
	} phase_t;

	typedef enum logic {
		KIND_TEXT   = 1'b0,
		KIND_OPTION = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       action;
		logic       line_end;
	} result_t;

endpackage

### design/telnet_noise_line_framer.sv
// Top level of the Telnet noise line framer.
// Instantiates tnlf_in_reg, tnlf_decode and tnlf_out_reg; uses tnlf_pkg.
//
// The byte channel (byte_valid, byte_ready, data_byte) takes one raw byte of a
// control stream per item. The record channel (rec_valid, rec_ready) delivers
// cleaned text bytes and Telnet option records on kind, value, action and
// line_end. IAC IAC gives a text byte 255, IAC WILL or IAC DO with a code gives
// an option record, and IAC with any other byte is dropped. A text LF right
// after a text CR carries line_end.
// One byte is accepted every cycle unless a stalled receiver holds back a record.
// A byte is held in the input register and decoded on its way into the output
// register. The decode is a single small state update, which sets the rate of
// one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its record and the input
// register still takes one more byte; bytes that yield no record keep moving.
// Reset clears both registers and returns the decoder to plain text.
module telnet_noise_line_framer
	import tnlf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	output logic       rec_valid,
	input  logic       rec_ready,
	output logic       kind,
	output logic [7:0] value,
	output logic       action,
	output logic       line_end
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       advance;
	logic       emit;
	logic       free;
	result_t    res;
	result_t    res_s2;

	assign advance = valid_s1 && (free || !emit);

	tnlf_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	tnlf_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.data_s1 (data_s1),
		.emit    (emit),
		.res     (res)
	);

	tnlf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && emit),
		.res       (res),
		.free      (free),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.res_s2    (res_s2)
	);

	assign kind     = res_s2.kind;
	assign value    = res_s2.value;
	assign action   = res_s2.action;
	assign line_end = res_s2.line_end;

endmodule

### design/tnlf_in_reg.sv
// Input register of the Telnet noise line framer.
// Holds one raw byte until the decoder consumes it; uses tnlf_pkg.
module tnlf_in_reg
	import tnlf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);

	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= data_byte;
		end
	end

endmodule

### design/tnlf_decode.sv
// Decoder of the Telnet noise line framer: phase, pending action and CR tracking.
// Turns one registered byte into zero or one result record; uses tnlf_pkg.
module tnlf_decode
	import tnlf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_s1,
	output logic       emit,
	output result_t    res
);

	phase_t phase_q, phase_d;
	logic   action_q, action_d;
	logic   cr_q, cr_d;
	logic   text;
	logic [7:0] text_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TEXT;
			action_q <= 1'b0;
			cr_q     <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			action_q <= action_d;
			cr_q     <= cr_d;
		end
	end

	always_comb begin
		phase_d   = PH_TEXT;
		action_d  = action_q;
		text      = 1'b0;
		text_byte = data_s1;
		emit      = 1'b0;
		res       = '0;
		case (phase_q)
			PH_IAC: begin
				if (data_s1 == CODE_IAC) begin
					text = 1'b1;
				end else if (data_s1 == CODE_WILL || data_s1 == CODE_DO) begin
					action_d = (data_s1 == CODE_DO);
					phase_d  = PH_OPT;
				end
			end
			PH_OPT: begin
				emit       = 1'b1;
				res.kind   = KIND_OPTION;
				res.value  = data_s1;
				res.action = action_q;
			end
			default: begin
				if (data_s1 == CODE_IAC) begin
					phase_d = PH_IAC;
				end else begin
					text = 1'b1;
				end
			end
		endcase
		cr_d = cr_q;
		if (text) begin
			emit         = 1'b1;
			res.kind     = KIND_TEXT;
			res.value    = text_byte;
			res.action   = 1'b0;
			res.line_end = (text_byte == CHAR_LF) && cr_q;
			cr_d         = (text_byte == CHAR_CR);
		end
	end

endmodule

### design/tnlf_out_reg.sv
// Output register of the Telnet noise line framer.
// Holds one result record until the receiver takes it; uses tnlf_pkg.
module tnlf_out_reg
	import tnlf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    free,
	output logic    rec_valid,
	input  logic    rec_ready,
	output result_t res_s2
);

	assign free = !rec_valid || rec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (free) begin
			rec_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_s2 <= res;
		end
	end

endmodule

### sim/tb_telnet_noise_line_framer.sv
// Testbench for telnet_noise_line_framer: drives raw control-stream bytes, predicts the
// cleaned text bytes and option records, and checks every record in order.
// Depends on tnlf_pkg and the telnet_noise_line_framer RTL.
module tb_telnet_noise_line_framer;
	import tnlf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [7:0] CODE_WONT = 8'd252;
	localparam logic [7:0] CODE_DONT = 8'd254;

	typedef struct {
		logic [7:0] data;
		bit         hold;
	} raw_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	logic [7:0] data_byte = 8'h00;
	logic       rec_valid;
	logic       rec_ready = 1'b0;
	logic       kind;
	logic [7:0] value;
	logic       action;
	logic       line_end;

	raw_byte_t  raw_q[$];
	result_t    record_q[$];

	phase_t     strip_phase = PH_TEXT;
	logic       strip_action = 1'b0;
	logic       strip_cr = 1'b0;

	int         bytes_sent = 0;
	int         rec_count = 0;
	int         n_text = 0;
	int         n_option = 0;
	int         n_line_end = 0;
	int         n_fail = 0;
	int         cyc = 0;
	int         tx_gap = 0;
	int         rx_gap = 0;
	int         rx_hold_left = 0;
	bit         rx_hold_done = 1'b0;

	telnet_noise_line_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.kind(kind),
		.value(value),
		.action(action),
		.line_end(line_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic push_text(input logic [7:0] b);
		result_t r;
		r.kind = KIND_TEXT;
		r.value = b;
		r.action = 1'b0;
		r.line_end = (b == CHAR_LF) && strip_cr;
		strip_cr = (b == CHAR_CR);
		record_q.push_back(r);
	endtask

	task automatic strip_byte(input logic [7:0] b);
		result_t r;
		case (strip_phase)
			PH_IAC: begin
				strip_phase = PH_TEXT;
				if (b == CODE_IAC) begin
					push_text(CODE_IAC);
				end else if (b == CODE_WILL || b == CODE_DO) begin
					strip_action = (b == CODE_DO);
					strip_phase = PH_OPT;
				end
			end
			PH_OPT: begin
				strip_phase = PH_TEXT;
				r.kind = KIND_OPTION;
				r.value = b;
				r.action = strip_action;
				r.line_end = 1'b0;
				record_q.push_back(r);
			end
			default: begin
				strip_phase = PH_TEXT;
				if (b == CODE_IAC)
					strip_phase = PH_IAC;
				else
					push_text(b);
			end
		endcase
	endtask

	task automatic add_byte(input logic [7:0] b, input bit hold = 1'b0);
		raw_byte_t it;
		it.data = b;
		it.hold = hold;
		raw_q.push_back(it);
	endtask

	// Byte sender: the held flag on an item makes it wait until all records are back.
	always @(posedge clk or negedge arst_n) begin
		raw_byte_t it;
		logic      offer;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			offer = byte_valid;
			if (byte_valid && byte_ready) begin
				strip_byte(data_byte);
				bytes_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (raw_q.size() > 0 &&
						!(raw_q[0].hold && record_q.size() > 0)) begin
					it = raw_q.pop_front();
					data_byte <= it.data;
					offer = 1'b1;
					tx_gap = ((bytes_sent / 80) % 4 == 1) ? 0 : pick_gap();
				end
			end
			byte_valid <= offer;
		end
	end

	// Record receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic    take;
		if (!arst_n) begin
			rec_ready <= 1'b0;
		end else begin
			if (rec_valid && rec_ready) begin
				rec_count++;
				if (record_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected record kind %0d value %h action %0d line_end %0d",
						$time, kind, value, action, line_end);
				end else begin
					want = record_q.pop_front();
					if (kind !== want.kind) begin
						n_fail++;
						$display("%0t: kind mismatch, expected %0d actual %0d",
							$time, want.kind, kind);
					end
					if (value !== want.value) begin
						n_fail++;
						$display("%0t: value mismatch, expected %h actual %h",
							$time, want.value, value);
					end
					if (action !== want.action) begin
						n_fail++;
						$display("%0t: action mismatch, expected %0d actual %0d",
							$time, want.action, action);
					end
					if (line_end !== want.line_end) begin
						n_fail++;
						$display("%0t: line_end mismatch, expected %0d actual %0d",
							$time, want.line_end, line_end);
					end
					if (want.kind == KIND_OPTION)
						n_option++;
					else
						n_text++;
					if (want.line_end)
						n_line_end++;
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				take = 1'b0;
			end else if (!rx_hold_done && rec_count >= 250) begin
				rx_hold_done = 1'b1;
				rx_hold_left = 100;
				take = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				rx_gap = ((rec_count / 70) % 4 == 2) ? 0 : pick_gap();
			end
			rec_ready <= take;
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int         kind_sel;
		int         len;
		logic [7:0] b;

		// Directed: plain bytes, CR LF, escaped 255, options with noise inside a line,
		// option codes that are IAC or LF, dropped commands and an escaped 255 before an LF.
		add_byte(8'h41);
		add_byte(8'h00);
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
		add_byte(CODE_IAC);
		add_byte(CODE_IAC);
		add_byte(CHAR_CR);
		add_byte(CODE_IAC);
		add_byte(CODE_WILL);
		add_byte(8'h01);
		add_byte(CHAR_LF);
		add_byte(CODE_IAC);
		add_byte(CODE_DO);
		add_byte(CODE_IAC);
		add_byte(CODE_IAC);
		add_byte(CODE_WONT);
		add_byte(CHAR_CR);
		add_byte(CODE_IAC);
		add_byte(CODE_DONT);
		add_byte(CODE_IAC);
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
		add_byte(CODE_IAC);
		add_byte(CODE_IAC);
		add_byte(CHAR_LF);
		add_byte(CODE_IAC);
		add_byte(CODE_DO);
		add_byte(CHAR_LF);
		add_byte(8'h80, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Random part: mostly well-formed command lines with Telnet noise mixed in.
		while (raw_q.size() + bytes_sent < 680) begin
			kind_sel = $urandom_range(0, 19);
			case (kind_sel)
				0, 1, 2, 3, 4: begin
					len = $urandom_range(1, 8);
					repeat (len) begin
						b = 8'($urandom_range(0, 254));
						add_byte(b, (raw_q.size() + bytes_sent) % 200 == 0);
					end
				end
				5, 6, 7: begin
					add_byte(CHAR_CR);
					if ($urandom_range(0, 3) == 0) begin
						add_byte(CODE_IAC);
						add_byte($urandom_range(0, 1) ? CODE_WILL : CODE_DO);
						add_byte(8'($urandom_range(0, 255)));
					end
					add_byte(CHAR_LF);
				end
				8, 9: begin
					add_byte(CODE_IAC);
					add_byte(CODE_IAC);
				end
				10, 11, 12: begin
					add_byte(CODE_IAC);
					add_byte($urandom_range(0, 1) ? CODE_WILL : CODE_DO);
					add_byte(8'($urandom_range(0, 255)));
				end
				13, 14: begin
					add_byte(CODE_IAC);
					add_byte($urandom_range(0, 1) ? CODE_WONT : CODE_DONT);
				end
				15, 16: begin
					add_byte(CODE_IAC);
					add_byte(8'($urandom_range(0, 250)));
				end
				default: begin
					len = $urandom_range(1, 4);
					repeat (len)
						add_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end

		while (raw_q.size() != 0 || byte_valid || record_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes; checked %0d text bytes, %0d option records, %0d line ends.",
			bytes_sent, n_text, n_option, n_line_end);
		$display("Covered escapes, dropped commands, noise inside CR LF and output back-pressure.");
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
